>>> hdl/stpax_pkg.sv
// ----------------------------------------------------------------------------
// stpax_pkg
// Shared widths, command codes, register indexes, control structs and the
// quadrature transition decode for the two-axis stepper controller.
// ----------------------------------------------------------------------------
package stpax_pkg;

  localparam int COUNT_BITS  = 32;
  localparam int PERIOD_BITS = 27;
  localparam int CLK_BITS    = 27;
  localparam int RATE_BITS   = 20;
  localparam int MIN_PERIOD  = 4;
  localparam int DIV_CNT_BITS = $clog2(CLK_BITS + 1);
  localparam int CFG_IDX_BITS = 3;
  localparam int NUM_AXES    = 2;

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_SET_STEP   = 3'd1,
    CMD_STOP       = 3'd2,
    CMD_SET_ENABLE = 3'd3,
    CMD_RESET_ENC  = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP_CLK0   = 3'd0,
    CFG_STEP_CLK1   = 3'd1,
    CFG_DIR_POL     = 3'd2,
    CFG_EN_ACT_HIGH = 3'd3,
    CFG_CNT_NEGATE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_COMMIT
  } state_e;

  typedef enum logic [1:0] {
    QD_HOLD,
    QD_UP,
    QD_DOWN
  } quad_dir_e;

  // One step-clock tick as taken from the input channel
  typedef struct packed {
    logic [2:0]           cmd;
    logic                 axis_select;
    logic                 move_positive;
    logic [RATE_BITS-1:0] step_rate;
    logic                 enable_request;
    logic [1:0]           quad_ab_axis0;
    logic [1:0]           quad_ab_axis1;
    logic [3:0]           limit_levels_n;
  } item_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic commit;
    logic use_held;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic needs_div;
    logic div_busy;
  } ctrl_stat_t;

  // 4x decode: index is {previous AB, current AB}; double jumps count nothing
  function automatic quad_dir_e quad_decode(input logic [3:0] idx);
    quad_dir_e d;
    case (idx) inside
      4'd2, 4'd4, 4'd11, 4'd13: d = QD_UP;
      4'd1, 4'd7, 4'd8, 4'd14:  d = QD_DOWN;
      default:                  d = QD_HOLD;
    endcase
    return d;
  endfunction

endpackage

>>> hdl/stpax_div.sv
// ----------------------------------------------------------------------------
// stpax_div
// Restoring divider, one quotient bit per cycle: step clock over step rate.
// ----------------------------------------------------------------------------
module stpax_div
  import stpax_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CLK_BITS-1:0]  dividend_i,
  input  logic [RATE_BITS-1:0] divisor_i,
  output logic                 busy_o,
  output logic [CLK_BITS-1:0]  quotient_o
);

  logic                    run_q, run_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [RATE_BITS-1:0]    rem_q, rem_d;
  logic [CLK_BITS-1:0]     quo_q, quo_d;
  logic [RATE_BITS-1:0]    dvs_q, dvs_d;
  logic [RATE_BITS:0]      rem_sh;
  logic [RATE_BITS:0]      diff;
  logic                    ge;

  assign rem_sh = {rem_q, quo_q[CLK_BITS-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = DIV_CNT_BITS'(CLK_BITS);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = ge ? diff[RATE_BITS-1:0] : rem_sh[RATE_BITS-1:0];
      quo_d = {quo_q[CLK_BITS-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_BITS'(1);
      if (cnt_q == DIV_CNT_BITS'(1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = run_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/stpax_ctrl.sv
// ----------------------------------------------------------------------------
// stpax_ctrl
// Sequencer: takes ticks, parks set-step ticks on the divider, and commits.
// ----------------------------------------------------------------------------
module stpax_ctrl
  import stpax_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  ctrl_stat_t stat_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && stat_i.slot_free && stat_i.needs_div) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!stat_i.div_busy) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (stat_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = stat_i.slot_free;
        if (in_valid_i && stat_i.slot_free) begin
          if (stat_i.needs_div) begin
            cmd_o.capture   = 1'b1;
            cmd_o.div_start = 1'b1;
          end else begin
            cmd_o.commit = 1'b1;
          end
        end
      end
      ST_COMMIT: begin
        cmd_o.use_held = 1'b1;
        cmd_o.commit   = stat_i.slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/stpax_dp.sv
// ----------------------------------------------------------------------------
// stpax_dp
// Axis state, step timers, encoder counters, config registers, result register.
// ----------------------------------------------------------------------------
module stpax_dp
  import stpax_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  item_t                         item_i,
  input  ctrl_cmd_t                     cmd_i,
  output ctrl_stat_t                    stat_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CLK_BITS-1:0]           cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [NUM_AXES-1:0]           step_pins_o,
  output logic [NUM_AXES-1:0]           dir_pins_o,
  output logic [NUM_AXES-1:0]           enable_pins_o,
  output logic [NUM_AXES-1:0]           running_mask_o,
  output logic signed [COUNT_BITS-1:0]  position_count_o,
  output logic [3:0]                    limit_active_o
);

  // configuration
  logic [CLK_BITS-1:0] clk0_q, clk1_q;
  logic [1:0]          dir_pol_q;
  logic                en_high_q;
  logic [1:0]          negate_q;

  // per-axis state
  logic [COUNT_BITS-1:0]  qc_q  [NUM_AXES];
  logic [COUNT_BITS-1:0]  qc_d  [NUM_AXES];
  logic [1:0]             ab_q  [NUM_AXES];
  logic [1:0]             ab_d  [NUM_AXES];
  logic [PERIOD_BITS-1:0] pl_q  [NUM_AXES];
  logic [PERIOD_BITS-1:0] pl_d  [NUM_AXES];
  logic [PERIOD_BITS-1:0] dc_q  [NUM_AXES];
  logic [PERIOD_BITS-1:0] dc_d  [NUM_AXES];
  logic [1:0]             lim_q [NUM_AXES];
  logic [1:0]             lim_d [NUM_AXES];
  logic [NUM_AXES-1:0]    run_q, run_d;
  logic [NUM_AXES-1:0]    dpos_q, dpos_d;
  logic [NUM_AXES-1:0]    en_q, en_d;

  item_t                  held_q;
  item_t                  it;
  logic [CLK_BITS-1:0]    quotient;
  logic                   div_busy;
  logic [PERIOD_BITS-1:0] period_m1;
  logic [1:0]             ab_in [NUM_AXES];

  // result register
  logic                   out_valid_q;
  logic [NUM_AXES-1:0]    step_q, step_d;
  logic [NUM_AXES-1:0]    dirp_q, dirp_d;
  logic [NUM_AXES-1:0]    enp_q, enp_d;
  logic [NUM_AXES-1:0]    runm_q;
  logic [COUNT_BITS-1:0]  pos_q, pos_d;
  logic [3:0]             lima_q;

  assign it = cmd_i.use_held ? held_q : item_i;
  assign ab_in[0] = it.quad_ab_axis0;
  assign ab_in[1] = it.quad_ab_axis1;

  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign stat_o.needs_div = (item_i.cmd == CMD_SET_STEP) && (item_i.step_rate != '0);
  assign stat_o.div_busy  = div_busy;

  stpax_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (it.axis_select ? clk1_q : clk0_q),
    .divisor_i  (it.step_rate),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // floor the period; the quotient cannot exceed the period range
  always_comb begin
    if (quotient < CLK_BITS'(MIN_PERIOD)) begin
      period_m1 = PERIOD_BITS'(MIN_PERIOD - 1);
    end else begin
      period_m1 = PERIOD_BITS'(quotient) - PERIOD_BITS'(1);
    end
  end

  // one tick: advance timers, apply command, limit edges, encoder decode
  always_comb begin
    logic [PERIOD_BITS:0] half;
    logic [1:0]           cur;
    quad_dir_e            qd;
    logic [COUNT_BITS-1:0] pos;
    half = '0;
    cur  = '0;
    qd   = QD_HOLD;
    pos  = '0;
    run_d  = run_q;
    dpos_d = dpos_q;
    en_d   = en_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      qc_d[i]  = qc_q[i];
      ab_d[i]  = ab_q[i];
      pl_d[i]  = pl_q[i];
      dc_d[i]  = dc_q[i];
      lim_d[i] = lim_q[i];
      if (run_q[i]) begin
        dc_d[i] = (dc_q[i] == '0) ? pl_q[i] : dc_q[i] - PERIOD_BITS'(1);
      end
    end

    case (cmd_e'(it.cmd))
      CMD_SET_STEP: begin
        if (it.step_rate != '0) begin
          dpos_d[it.axis_select] = it.move_positive;
          pl_d[it.axis_select]   = period_m1;
          dc_d[it.axis_select]   = period_m1;
          run_d[it.axis_select]  = 1'b1;
        end else begin
          run_d[it.axis_select] = 1'b0;
        end
      end
      CMD_STOP:       run_d[it.axis_select] = 1'b0;
      CMD_SET_ENABLE: en_d[it.axis_select] = it.enable_request;
      CMD_RESET_ENC: begin
        qc_d[it.axis_select] = '0;
        ab_d[it.axis_select] = ab_in[it.axis_select];
      end
      default: ;
    endcase

    for (int i = 0; i < NUM_AXES; i++) begin
      cur = it.limit_levels_n[2*i +: 2];
      // falling edge on a limit wins over a same-tick set step
      if ((lim_q[i] & ~cur) != 2'b00) begin
        run_d[i] = 1'b0;
      end
      lim_d[i] = cur;

      qd = quad_decode({ab_d[i], ab_in[i]});
      if (qd == QD_UP) begin
        qc_d[i] = qc_d[i] + COUNT_BITS'(1);
      end else if (qd == QD_DOWN) begin
        qc_d[i] = qc_d[i] - COUNT_BITS'(1);
      end
      ab_d[i] = ab_in[i];

      half      = ({1'b0, pl_d[i]} + (PERIOD_BITS+1)'(1)) >> 1;
      step_d[i] = run_d[i] && ({1'b0, dc_d[i]} < half);
      dirp_d[i] = ~(dir_pol_q[i] ^ dpos_d[i]);
      enp_d[i]  = ~(en_high_q ^ en_d[i]);
    end

    pos = qc_d[it.axis_select];
    if (negate_q[it.axis_select]) begin
      pos = COUNT_BITS'(0) - pos;
    end
    pos_d = pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk0_q    <= CLK_BITS'(1000000);
      clk1_q    <= CLK_BITS'(1000000);
      dir_pol_q <= 2'b11;
      en_high_q <= 1'b1;
      negate_q  <= 2'b00;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_CLK0:   clk0_q    <= cfg_data_i;
        CFG_STEP_CLK1:   clk1_q    <= cfg_data_i;
        CFG_DIR_POL:     dir_pol_q <= cfg_data_i[1:0];
        CFG_EN_ACT_HIGH: en_high_q <= cfg_data_i[0];
        CFG_CNT_NEGATE:  negate_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        qc_q[i]  <= '0;
        ab_q[i]  <= '0;
        pl_q[i]  <= '0;
        dc_q[i]  <= '0;
        lim_q[i] <= 2'b11;
      end
      run_q  <= '0;
      dpos_q <= '0;
      en_q   <= '0;
    end else if (cmd_i.commit) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        qc_q[i]  <= qc_d[i];
        ab_q[i]  <= ab_d[i];
        pl_q[i]  <= pl_d[i];
        dc_q[i]  <= dc_d[i];
        lim_q[i] <= lim_d[i];
      end
      run_q  <= run_d;
      dpos_q <= dpos_d;
      en_q   <= en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      held_q <= item_i;
    end
    if (cmd_i.commit) begin
      step_q <= step_d;
      dirp_q <= dirp_d;
      enp_q  <= enp_d;
      runm_q <= run_d;
      pos_q  <= pos_d;
      lima_q <= ~it.limit_levels_n;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_pins_o      = step_q;
  assign dir_pins_o       = dirp_q;
  assign enable_pins_o    = enp_q;
  assign running_mask_o   = runm_q;
  assign position_count_o = signed'(pos_q);
  assign limit_active_o   = lima_q;

  a_commit_has_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> stat_o.slot_free)
    else $error("commit while result register is occupied");

  a_held_commit_div_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && cmd_i.use_held) |-> !div_busy)
    else $error("set step committed before quotient is ready");

  a_counter_in_period0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> dc_q[0] <= pl_q[0])
    else $error("axis 0 step counter above its period");

  a_counter_in_period1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> dc_q[1] <= pl_q[1])
    else $error("axis 1 step counter above its period");

endmodule

>>> hdl/stepper_axis_step_and_encoder.sv
// ----------------------------------------------------------------------------
// stepper_axis_step_and_encoder
// Two-axis stepper step generator with 4x quadrature decoders and limit stops.
// ----------------------------------------------------------------------------
// Timing: a tick is committed at its transfer and its result can transfer in the
//   following cycle; a set step tick with nonzero rate is committed once the divider is done.
// Throughput: one tick per cycle while the result register is free; a set step with
//   nonzero rate holds the input while the bit-serial period divider runs.
// Reset: axes stopped and disabled, counts zero, config at its defaults.
module stepper_axis_step_and_encoder
  import stpax_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    cmd_i,
  input  logic                          axis_select_i,
  input  logic                          move_positive_i,
  input  logic [RATE_BITS-1:0]          step_rate_i,
  input  logic                          enable_request_i,
  input  logic [1:0]                    quad_ab_axis0_i,
  input  logic [1:0]                    quad_ab_axis1_i,
  input  logic [3:0]                    limit_levels_n_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [NUM_AXES-1:0]           step_pins_o,
  output logic [NUM_AXES-1:0]           dir_pins_o,
  output logic [NUM_AXES-1:0]           enable_pins_o,
  output logic [NUM_AXES-1:0]           running_mask_o,
  output logic signed [COUNT_BITS-1:0]  position_count_o,
  output logic [3:0]                    limit_active_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CLK_BITS-1:0]           cfg_data_i
);

  item_t      item;
  ctrl_cmd_t  ctrl_cmd;
  ctrl_stat_t ctrl_stat;

  assign item.cmd            = cmd_i;
  assign item.axis_select    = axis_select_i;
  assign item.move_positive  = move_positive_i;
  assign item.step_rate      = step_rate_i;
  assign item.enable_request = enable_request_i;
  assign item.quad_ab_axis0  = quad_ab_axis0_i;
  assign item.quad_ab_axis1  = quad_ab_axis1_i;
  assign item.limit_levels_n = limit_levels_n_i;

  assign cfg_ready_o = 1'b1;

  stpax_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (ctrl_stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (ctrl_cmd)
  );

  stpax_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .cmd_i            (ctrl_cmd),
    .stat_o           (ctrl_stat),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .step_pins_o      (step_pins_o),
    .dir_pins_o       (dir_pins_o),
    .enable_pins_o    (enable_pins_o),
    .running_mask_o   (running_mask_o),
    .position_count_o (position_count_o),
    .limit_active_o   (limit_active_o)
  );

endmodule
